### rtl/fdci_pkg.sv
// shared types, constants and the microprogram of the fractional delay line
// no dependencies; used by fdci_seq, fdci_dp and the top level
package fdci_pkg;

  // configuration register widths and reset values
  localparam int DELAY_W    = 29;
  localparam int LENGTH_W   = 14;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 29;
  localparam logic [LENGTH_W-1:0] LENGTH_RST = LENGTH_W'(8192);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY  = 1'b0,
    CFG_LENGTH = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic                  we;
    cfg_idx_e              idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // microprogram fields
  typedef enum logic [2:0] {
    RD_NONE,
    RD_I0,
    RD_I1,
    RD_I2,
    RD_I3
  } rd_sel_e;

  typedef enum logic [2:0] {
    LDB_NONE,
    LDB_B0,
    LDB_B1,
    LDB_B2,
    LDB_B3
  } ldb_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_TT,
    MUL_DIV,
    MUL_WB0,
    MUL_XB1,
    MUL_YB2,
    MUL_ZB3,
    MUL_AT
  } mul_sel_e;

  typedef enum logic [3:0] {
    ALU_NONE,
    ALU_LEN,
    ALU_CLAMP,
    ALU_BASE,
    ALU_TT,
    ALU_Z,
    ALU_COEF,
    ALU_SUM_CLR,
    ALU_SUM_ADD,
    ALU_ACC_RND,
    ALU_DIFF,
    ALU_OUT
  } alu_op_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_SHORT,
    JMP_ALWAYS,
    JMP_DONE
  } jmp_e;

  localparam int PC_W     = 5;
  localparam int PROG_LEN = 17;
  localparam logic [PC_W-1:0] PC_ROUND  = PC_W'(14);
  localparam logic [PC_W-1:0] PC_LINEAR = PC_W'(16);

  typedef struct packed {
    rd_sel_e          rd;
    ldb_e             ldb;
    mul_sel_e         mul;
    alu_op_e          alu;
    jmp_e             jmp;
    logic [PC_W-1:0]  target;
  } ctrl_word_t;

  localparam ctrl_word_t CTRL_NOP = '{RD_NONE, LDB_NONE, MUL_NONE, ALU_NONE, JMP_NEXT, '0};

  // datapath status seen by the sequencer and the top level
  typedef struct packed {
    logic short_ring;
    logic out_blocked;
    logic clearing;
  } dp_status_t;

  function automatic ctrl_word_t uw(input rd_sel_e rd, input ldb_e ldb, input mul_sel_e mul,
                                    input alu_op_e alu, input jmp_e jmp,
                                    input logic [PC_W-1:0] target);
    ctrl_word_t w;
    w.rd     = rd;
    w.ldb    = ldb;
    w.mul    = mul;
    w.alu    = alu;
    w.jmp    = jmp;
    w.target = target;
    return w;
  endfunction

  // control store: one word per step
  function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    case (pc)
      PC_W'(0):  w = uw(RD_NONE, LDB_NONE, MUL_NONE, ALU_LEN,     JMP_NEXT,   '0);
      PC_W'(1):  w = uw(RD_NONE, LDB_NONE, MUL_NONE, ALU_CLAMP,   JMP_NEXT,   '0);
      PC_W'(2):  w = uw(RD_NONE, LDB_NONE, MUL_NONE, ALU_BASE,    JMP_NEXT,   '0);
      PC_W'(3):  w = uw(RD_I1,   LDB_NONE, MUL_TT,   ALU_NONE,    JMP_NEXT,   '0);
      PC_W'(4):  w = uw(RD_I2,   LDB_B1,   MUL_NONE, ALU_TT,      JMP_NEXT,   '0);
      PC_W'(5):  w = uw(RD_I0,   LDB_B2,   MUL_DIV,  ALU_NONE,    JMP_SHORT,  PC_LINEAR);
      PC_W'(6):  w = uw(RD_I3,   LDB_B0,   MUL_NONE, ALU_Z,       JMP_NEXT,   '0);
      PC_W'(7):  w = uw(RD_NONE, LDB_B3,   MUL_NONE, ALU_COEF,    JMP_NEXT,   '0);
      PC_W'(8):  w = uw(RD_NONE, LDB_NONE, MUL_WB0,  ALU_NONE,    JMP_NEXT,   '0);
      PC_W'(9):  w = uw(RD_NONE, LDB_NONE, MUL_XB1,  ALU_SUM_CLR, JMP_NEXT,   '0);
      PC_W'(10): w = uw(RD_NONE, LDB_NONE, MUL_YB2,  ALU_SUM_ADD, JMP_NEXT,   '0);
      PC_W'(11): w = uw(RD_NONE, LDB_NONE, MUL_ZB3,  ALU_SUM_ADD, JMP_NEXT,   '0);
      PC_W'(12): w = uw(RD_NONE, LDB_NONE, MUL_NONE, ALU_SUM_ADD, JMP_NEXT,   '0);
      PC_W'(13): w = uw(RD_NONE, LDB_NONE, MUL_NONE, ALU_ACC_RND, JMP_NEXT,   '0);
      PC_ROUND:  w = uw(RD_NONE, LDB_NONE, MUL_AT,   ALU_NONE,    JMP_NEXT,   '0);
      PC_W'(15): w = uw(RD_NONE, LDB_NONE, MUL_NONE, ALU_OUT,     JMP_DONE,   '0);
      PC_LINEAR: w = uw(RD_NONE, LDB_NONE, MUL_NONE, ALU_DIFF,    JMP_ALWAYS, PC_ROUND);
      default:   w = uw(RD_NONE, LDB_NONE, MUL_NONE, ALU_NONE,    JMP_DONE,   '0);
    endcase
    return w;
  endfunction

endpackage

### rtl/fdci_stream_if.sv
// valid/ready stream channel carrying one audio sample per word
// no dependencies
interface fdci_stream_if #(
  parameter int WIDTH = 24
) ();
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

### rtl/fdci_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module fdci_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8192,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/fdci_seq.sv
// microcode sequencer: step counter, control store lookup, conditional jumps
// depends on fdci_pkg
module fdci_seq
  import fdci_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t status_i,
  output ctrl_word_t ctrl_o,
  output logic       idle_o
);

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  seq_state_e      state_q;
  logic [PC_W-1:0] pc_q;
  ctrl_word_t      word;
  logic            stall;

  assign word   = ucode_rom(pc_q);
  // hold the last step until the output slot frees up
  assign stall  = (word.jmp == JMP_DONE) && status_i.out_blocked;
  assign ctrl_o = (state_q == SEQ_RUN && !stall) ? word : CTRL_NOP;
  assign idle_o = (state_q == SEQ_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      pc_q    <= '0;
    end else begin
      case (state_q)
        SEQ_IDLE: begin
          if (start_i) begin
            state_q <= SEQ_RUN;
            pc_q    <= '0;
          end
        end
        SEQ_RUN: begin
          if (!stall) begin
            case (word.jmp)
              JMP_NEXT:   pc_q <= pc_q + PC_W'(1);
              JMP_SHORT:  pc_q <= status_i.short_ring ? word.target : pc_q + PC_W'(1);
              JMP_ALWAYS: pc_q <= word.target;
              JMP_DONE:   state_q <= SEQ_IDLE;
              default:    state_q <= SEQ_IDLE;
            endcase
          end
        end
        default: state_q <= SEQ_IDLE;
      endcase
    end
  end

  a_pc_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_RUN) |-> (pc_q < PC_W'(PROG_LEN)))
    else $error("step counter left the program");

endmodule

### rtl/fdci_dp.sv
// datapath: config registers, ring index unit, sample ram, shared multiplier,
// accumulator and output register; depends on fdci_pkg and fdci_ram
module fdci_dp
  import fdci_pkg::*;
#(
  parameter int BUF_DEPTH   = 8192,
  parameter int FRAC_BITS   = 16,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_wr_t                       cfg_i,
  input  ctrl_word_t                    ctrl_i,
  input  logic                          start_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic signed [SAMPLE_BITS-1:0] out_sample_o,
  output dp_status_t                    status_o
);

  localparam int AW     = $clog2(BUF_DEPTH);
  localparam int LW     = $clog2(BUF_DEPTH + 1);
  localparam int LCMP   = (LW > LENGTH_W) ? LW : LENGTH_W;
  localparam int DCMP   = (LW + FRAC_BITS > DELAY_W) ? LW + FRAC_BITS : DELAY_W;
  localparam int CW     = FRAC_BITS + 3;
  localparam int ACCW   = SAMPLE_BITS + 3;
  localparam int MA     = (ACCW > FRAC_BITS + 2) ? ACCW : FRAC_BITS + 2;
  localparam int MB     = CW;
  localparam int PW     = MA + MB;
  localparam int SW     = PW + 2;
  localparam int ROW    = SAMPLE_BITS + 3;
  localparam int DIV_SH = FRAC_BITS + 1;
  localparam int DIV_MUL = (1 << DIV_SH) / 6;
  localparam int QW     = FRAC_BITS + 4;

  localparam logic [FRAC_BITS:0]      ONE_V  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [CW-1:0]    ONE_C  = {3'b001, {FRAC_BITS{1'b0}}};
  localparam logic signed [SW-1:0]    HALF_S = SW'(1) << (FRAC_BITS - 1);
  localparam logic signed [PW-1:0]    HALF_P = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [ROW-1:0]   SAT_HI =
    {{(ROW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [ROW-1:0]   SAT_LO =
    {{(ROW - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

  // control registers
  logic [DELAY_W-1:0]  delay_cfg_q;
  logic [LENGTH_W-1:0] ring_cfg_q;
  logic [AW-1:0]       wp_q;
  logic                clearing_q;
  logic [AW-1:0]       clr_q;
  logic                out_valid_q;

  // working registers
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [LW-1:0]                 len_q;
  logic [DELAY_W-1:0]            d_q;
  logic [AW-1:0]                 base_q;
  logic [FRAC_BITS-1:0]          t_q;
  logic signed [SAMPLE_BITS-1:0] b0_q, b1_q, b2_q, b3_q;
  logic signed [PW-1:0]          prod_q;
  logic [FRAC_BITS:0]            v_q;
  logic signed [CW-1:0]          z_q, w_q, x_q, y_q;
  logic signed [SW-1:0]          sum_q;
  logic signed [ACCW-1:0]        acc_q;
  logic signed [SAMPLE_BITS-1:0] out_q;

  // ring geometry
  logic [LCMP-1:0]      ring_ext;
  logic [LW-1:0]        len_d;
  logic [AW-1:0]        wp_fix;
  logic [DCMP-1:0]      dmax;
  logic [DELAY_W-1:0]   d_d;
  logic [AW-1:0]        di;
  logic [FRAC_BITS-1:0] frac;
  logic                 fnz;
  logic [LW:0]          base_sum;
  logic [AW-1:0]        base_d;
  logic [FRAC_BITS-1:0] t_d;
  logic [LW-1:0]        wp_inc;
  logic [AW-1:0]        wp_adv;

  assign ring_ext = LCMP'(ring_cfg_q);
  assign len_d    = (ring_cfg_q == '0) ? LW'(1) :
                    (ring_ext > LCMP'(BUF_DEPTH)) ? LW'(BUF_DEPTH) : LW'(ring_cfg_q);
  assign wp_fix   = (LW'(wp_q) >= len_q) ? '0 : wp_q;
  assign dmax     = DCMP'(len_q - LW'(1)) << FRAC_BITS;
  assign d_d      = (DCMP'(delay_cfg_q) > dmax) ? DELAY_W'(dmax) : delay_cfg_q;
  assign di       = AW'(DCMP'(d_q) >> FRAC_BITS);
  assign frac     = d_q[FRAC_BITS-1:0];
  assign fnz      = |frac;
  // wp - di - (frac != 0) lies in [-len, len), biased by len
  assign base_sum = {1'b0, LW'(wp_q)} + {1'b0, len_q} - (LW + 1)'(di) - (LW + 1)'(fnz);
  assign base_d   = (base_sum >= {1'b0, len_q}) ? AW'(base_sum - {1'b0, len_q})
                                                : AW'(base_sum);
  assign t_d      = fnz ? (~frac) + FRAC_BITS'(1) : '0;
  assign wp_inc   = LW'(wp_q) + LW'(1);
  assign wp_adv   = (wp_inc == len_q) ? '0 : AW'(wp_inc);

  // neighbour indices around base
  logic [AW-1:0] i0, i2, i3, raddr;
  logic [LW-1:0] p1;
  logic [LW:0]   p2;

  assign i0 = (base_q == '0) ? AW'(len_q - LW'(1)) : base_q - AW'(1);
  assign p1 = LW'(base_q) + LW'(1);
  assign i2 = (p1 == len_q) ? '0 : AW'(p1);
  assign p2 = (LW + 1)'(base_q) + (LW + 1)'(2);
  assign i3 = (p2 >= {1'b0, len_q}) ? AW'(p2 - {1'b0, len_q}) : AW'(p2);

  always_comb begin
    case (ctrl_i.rd)
      RD_I0:   raddr = i0;
      RD_I1:   raddr = base_q;
      RD_I2:   raddr = i2;
      RD_I3:   raddr = i3;
      default: raddr = base_q;
    endcase
  end

  // sample store, swept to zero after reset
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  assign ram_we    = clearing_q || (ctrl_i.alu == ALU_BASE);
  assign ram_waddr = clearing_q ? clr_q : wp_q;
  assign ram_wdata = clearing_q ? '0 : sample_q;

  fdci_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (BUF_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // shared multiplier operands
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;

  always_comb begin
    case (ctrl_i.mul)
      MUL_TT: begin
        mul_a = MA'(t_q);
        mul_b = MB'(t_q);
      end
      MUL_DIV: begin
        mul_a = MA'(v_q);
        mul_b = MB'(DIV_MUL);
      end
      MUL_WB0: begin
        mul_a = MA'(b0_q);
        mul_b = w_q;
      end
      MUL_XB1: begin
        mul_a = MA'(b1_q);
        mul_b = x_q;
      end
      MUL_YB2: begin
        mul_a = MA'(b2_q);
        mul_b = y_q;
      end
      MUL_ZB3: begin
        mul_a = MA'(b3_q);
        mul_b = z_q;
      end
      MUL_AT: begin
        mul_a = MA'(acc_q);
        mul_b = MB'(t_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // coefficient arithmetic
  logic [FRAC_BITS-1:0] tt;
  logic [FRAC_BITS:0]   v_d;
  logic [FRAC_BITS-1:0] q0;
  logic [QW-1:0]        six_q0;
  logic [QW-1:0]        rem;
  logic                 corr;
  logic signed [CW-1:0] z_d;
  logic signed [CW-1:0] hs, z3, y_d, w_d, x_d;

  assign tt     = prod_q[2*FRAC_BITS-1:FRAC_BITS];
  assign v_d    = ONE_V - {1'b0, tt};
  // quotient by six through the reciprocal, low by at most one
  assign q0     = prod_q[DIV_SH +: FRAC_BITS];
  assign six_q0 = (QW'(q0) << 2) + (QW'(q0) << 1);
  assign rem    = QW'(v_q) - six_q0;
  assign corr   = (rem >= QW'(6));
  assign z_d    = CW'(0) - CW'(q0) - CW'(corr);
  assign hs     = CW'({1'b1, t_q[FRAC_BITS-1:1]});
  assign z3     = z_q + (z_q <<< 1);
  assign y_d    = hs - z3;
  assign w_d    = hs - ONE_C - z_q;
  assign x_d    = z3 - CW'(t_q);

  // rounding and final sum
  logic signed [SW-1:0]   sum_rnd;
  logic signed [ACCW-1:0] acc_rnd;
  logic signed [ACCW-1:0] diff;
  logic signed [PW-1:0]   prod_rnd;
  logic signed [ROW-1:0]  res;
  logic signed [SAMPLE_BITS-1:0] res_sat;

  assign sum_rnd  = sum_q + HALF_S;
  assign acc_rnd  = ACCW'(sum_rnd >>> FRAC_BITS);
  assign diff     = ACCW'(b2_q) - ACCW'(b1_q);
  assign prod_rnd = prod_q + HALF_P;
  assign res      = ROW'(prod_rnd >>> FRAC_BITS) + ROW'(b1_q);
  assign res_sat  = (res > SAT_HI) ? SAMPLE_BITS'(SAT_HI) :
                    (res < SAT_LO) ? SAMPLE_BITS'(SAT_LO) : SAMPLE_BITS'(res);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_cfg_q <= '0;
      ring_cfg_q  <= LENGTH_RST;
      wp_q        <= '0;
      clearing_q  <= 1'b1;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.we) begin
        case (cfg_i.idx)
          CFG_DELAY:  delay_cfg_q <= DELAY_W'(cfg_i.data);
          CFG_LENGTH: ring_cfg_q  <= LENGTH_W'(cfg_i.data);
          default:    ;
        endcase
      end
      if (clearing_q) begin
        clr_q <= clr_q + AW'(1);
        if (clr_q == AW'(BUF_DEPTH - 1)) begin
          clearing_q <= 1'b0;
        end
      end
      case (ctrl_i.alu)
        ALU_CLAMP: wp_q <= wp_fix;
        ALU_BASE:  wp_q <= wp_adv;
        default:   ;
      endcase
      if (ctrl_i.alu == ALU_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sample_q <= sample_i;
    end
    case (ctrl_i.ldb)
      LDB_B0:  b0_q <= ram_rdata;
      LDB_B1:  b1_q <= ram_rdata;
      LDB_B2:  b2_q <= ram_rdata;
      LDB_B3:  b3_q <= ram_rdata;
      default: ;
    endcase
    if (ctrl_i.mul != MUL_NONE) begin
      prod_q <= mul_a * mul_b;
    end
    case (ctrl_i.alu)
      ALU_LEN:     len_q <= len_d;
      ALU_CLAMP:   d_q <= d_d;
      ALU_BASE: begin
        base_q <= base_d;
        t_q    <= t_d;
      end
      ALU_TT:      v_q <= v_d;
      ALU_Z:       z_q <= z_d;
      ALU_COEF: begin
        w_q <= w_d;
        x_q <= x_d;
        y_q <= y_d;
      end
      ALU_SUM_CLR: sum_q <= SW'(prod_q);
      ALU_SUM_ADD: sum_q <= sum_q + SW'(prod_q);
      ALU_ACC_RND: acc_q <= acc_rnd;
      ALU_DIFF:    acc_q <= diff;
      ALU_OUT:     out_q <= res_sat;
      default:     ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_q;

  assign status_o.short_ring  = (len_q < LW'(4));
  assign status_o.out_blocked = out_valid_q && !out_ready_i;
  assign status_o.clearing    = clearing_q;

  a_no_write_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.alu == ALU_BASE) |-> !clearing_q)
    else $error("sample write during clearing pass");

  a_out_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.alu == ALU_OUT) |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote a word not yet taken");

  a_wp_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.alu == ALU_BASE) |=> (LW'(wp_q) < len_q))
    else $error("write pointer outside active ring");

  a_read_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.rd != RD_NONE) |-> (LW'(raddr) < len_q))
    else $error("read index outside active ring");

endmodule

### rtl/fractional_delay_cubic_interp.sv
// top level of the fractional delay line with cubic interpolation
// depends on fdci_pkg, fdci_stream_if, fdci_seq, fdci_dp and fdci_ram
//
// Each input word is one signed sample. It is written into a circular buffer
// whose active length comes from the ring_length register (0 acts as 1, values
// above BUF_DEPTH act as BUF_DEPTH), and the block returns one output word: the
// signal delayed by delay_samples (FRAC_BITS fractional bits, clamped to length
// minus one), measured back from the sample just written. Rings of four or more
// entries use third-order Lagrange interpolation over four neighbours; shorter
// rings interpolate linearly between two. The result is rounded and saturated.
// Timing: after reset the buffer is swept to zero, one entry per cycle, over all
// BUF_DEPTH entries (8192 by default); no sample is taken during that sweep,
// configuration writes are. After that, each word is accepted and then run
// through the cubic or the linear microprogram, whose steps share the single
// multiplier and the single ram read port in turn; no new sample is taken
// until the microprogram is done. A new sample is taken while the previous
// result still waits in the output register; the sequencer only holds on its
// last step if that register is still full.
module fractional_delay_cubic_interp
  import fdci_pkg::*;
#(
  parameter int BUF_DEPTH   = 8192,
  parameter int FRAC_BITS   = 16,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // sample streams
  fdci_stream_if.sink           sample_in_i,
  fdci_stream_if.source         sample_out_o
);

  cfg_wr_t    cfg_wr;
  ctrl_word_t ctrl;
  dp_status_t dp_status;
  logic       seq_idle;
  logic       in_ready;
  logic       start;

  assign cfg_wr.we   = cfg_we_i;
  assign cfg_wr.idx  = cfg_idx_e'(cfg_idx_i);
  assign cfg_wr.data = cfg_data_i;

  // take a word whenever the sequencer is free and the sweep is over
  assign in_ready          = seq_idle && !dp_status.clearing;
  assign sample_in_i.ready = in_ready;
  assign start             = sample_in_i.valid && in_ready;

  fdci_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (dp_status),
    .ctrl_o   (ctrl),
    .idle_o   (seq_idle)
  );

  fdci_dp #(
    .BUF_DEPTH   (BUF_DEPTH),
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_wr),
    .ctrl_i       (ctrl),
    .start_i      (start),
    .sample_i     (sample_in_i.sample),
    .out_ready_i  (sample_out_o.ready),
    .out_valid_o  (sample_out_o.valid),
    .out_sample_o (sample_out_o.sample),
    .status_o     (dp_status)
  );

endmodule
